// ===== src/cat_pkg.sv =====
// Shared types and constants for the cumulative acknowledgement tracker.
`timescale 1ns / 1ps

package cat_pkg;

  localparam int DEFAULT_WINDOW   = 64;
  localparam int DEFAULT_SEQ_BITS = 16;

  localparam int SEQ_W    = 16;
  localparam int STATUS_W = 3;

  localparam logic [SEQ_W-1:0] LAST_CHUNK_RESET = 16'd1;

  localparam logic OP_ARRIVAL = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADVANCED = 3'd0,
    ST_PENDING  = 3'd1,
    ST_OLD      = 3'd2,
    ST_DROPPED  = 3'd3,
    ST_CLEARED  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EVAL,
    S_WALK,
    S_CLEAR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [SEQ_W-1:0] acked_count;
    logic             complete;
    status_e          status;
  } res_t;

endpackage

// ===== src/cumulative_ack_tracker.sv =====
// Top level of the cumulative acknowledgement tracker.
`timescale 1ns / 1ps

// Tracks the highest gap-free chunk number of one transfer.
// Input channel (in_valid_i / in_ready_o) carries op_i and seq_i; op_i set
// clears the tracker for a new transfer. Every request gives exactly one
// result on the output channel (out_valid_o / out_ready_i): acked_count_o,
// complete_o and status_o. The configuration channel (cfg_valid_i /
// cfg_ready_o) writes the final chunk number and is always ready.
// Pending chunks live in a one-bit-wide RAM of WINDOW entries with a
// registered read port; chunks more than WINDOW ahead are dropped.
// One request at a time: an old, dropped or pending chunk goes from S_EVAL
// to S_DONE, and the next request is taken once its result is loaded.
// An in-order chunk also runs the catch-up walk, which absorbs pending
// chunks until a RAM read shows none, WINDOW chunks are taken or the count
// reaches its maximum. A clear sweeps the RAM, one entry a cycle.
// After reset the same sweep runs with in_ready_o low.
// A finished result waits in the output register; if the receiver stalls,
// the next request is still accepted and processed, and only its result
// waits until the register frees.

module cumulative_ack_tracker #(
  parameter int WINDOW   = cat_pkg::DEFAULT_WINDOW,
  parameter int SEQ_BITS = cat_pkg::DEFAULT_SEQ_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic [cat_pkg::SEQ_W-1:0]     seq_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cat_pkg::SEQ_W-1:0]     acked_count_o,
  output logic                          complete_o,
  output logic [cat_pkg::STATUS_W-1:0]  status_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cat_pkg::SEQ_W-1:0]     last_chunk_seq_i
);

  localparam int AW = $clog2(WINDOW);

  logic [cat_pkg::SEQ_W-1:0] last_chunk_q, last_chunk_d;
  logic                      out_free;
  logic                      res_load;
  cat_pkg::res_t             res;
  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic                      ram_wdata;
  logic [AW-1:0]             ram_raddr;
  logic                      ram_rdata;

  assign cfg_ready_o  = 1'b1;
  assign last_chunk_d = (cfg_valid_i && cfg_ready_o) ? last_chunk_seq_i : last_chunk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_chunk_q <= cat_pkg::LAST_CHUNK_RESET;
    end else begin
      last_chunk_q <= last_chunk_d;
    end
  end

  cat_ctrl #(
    .WINDOW   (WINDOW),
    .SEQ_BITS (SEQ_BITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .seq_i            (seq_i),
    .last_chunk_seq_i (last_chunk_q),
    .out_free_i       (out_free),
    .res_load_o       (res_load),
    .res_o            (res),
    .ram_we_o         (ram_we),
    .ram_waddr_o      (ram_waddr),
    .ram_wdata_o      (ram_wdata),
    .ram_raddr_o      (ram_raddr),
    .ram_rdata_i      (ram_rdata)
  );

  cat_ram #(
    .WIDTH (1),
    .DEPTH (WINDOW)
  ) u_pending_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cat_outbuf u_outbuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (res_load),
    .res_i         (res),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .acked_count_o (acked_count_o),
    .complete_o    (complete_o),
    .status_o      (status_o)
  );

endmodule

// ===== src/cat_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module cat_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/cat_ctrl.sv =====
// Sequencer: classifies each request, updates the pending bitmap and walks it.
`timescale 1ns / 1ps

module cat_ctrl #(
  parameter int WINDOW   = cat_pkg::DEFAULT_WINDOW,
  parameter int SEQ_BITS = cat_pkg::DEFAULT_SEQ_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        op_i,
  input  logic [cat_pkg::SEQ_W-1:0]   seq_i,
  input  logic [cat_pkg::SEQ_W-1:0]   last_chunk_seq_i,
  input  logic                        out_free_i,
  output logic                        res_load_o,
  output cat_pkg::res_t               res_o,
  output logic                        ram_we_o,
  output logic [$clog2(WINDOW)-1:0]   ram_waddr_o,
  output logic                        ram_wdata_o,
  output logic [$clog2(WINDOW)-1:0]   ram_raddr_o,
  input  logic                        ram_rdata_i
);

  localparam int AW  = $clog2(WINDOW);
  localparam int WCW = $clog2(WINDOW + 1);
  localparam logic [AW-1:0]  SLOT_LAST = AW'(WINDOW - 1);
  localparam logic [AW:0]    WIN_SUM   = (AW + 1)'(WINDOW);
  localparam logic [WCW-1:0] WALK_MAX  = WCW'(WINDOW);

  cat_pkg::state_e  state_q, state_d;
  cat_pkg::status_e status_q, status_d;
  logic                op_q, op_d;
  logic [SEQ_BITS-1:0] seq_q, seq_d;
  logic [SEQ_BITS-1:0] acked_q, acked_d;
  logic [AW-1:0]       slot_q, slot_d;
  logic [WCW-1:0]      walked_q, walked_d;
  logic [AW-1:0]       sweep_q, sweep_d;

  logic [SEQ_BITS:0]   acked_p1;
  logic [SEQ_BITS:0]   seq_wide;
  logic [SEQ_BITS-1:0] diff;
  logic [AW:0]         pend_sum;
  logic [AW-1:0]       pend_slot;
  logic [AW-1:0]       slot_n1;
  logic [AW-1:0]       slot_n2;
  logic                is_next;
  logic                is_ahead;
  logic                in_window;
  logic                sweep_end;
  logic                walk_take;
  logic                walk_last;

  function automatic logic [AW-1:0] inc_slot(input logic [AW-1:0] s);
    return (s == SLOT_LAST) ? '0 : AW'(s + 1'b1);
  endfunction

  // The acked count's slot is tracked alongside the count, so a chunk's slot
  // follows from its distance ahead with one compare and subtract.
  assign acked_p1  = {1'b0, acked_q} + 1'b1;
  assign seq_wide  = {1'b0, seq_q};
  assign is_next   = (seq_wide == acked_p1);
  assign is_ahead  = (seq_wide > acked_p1);
  assign diff      = seq_q - acked_q;
  assign in_window = (33'(diff) <= 33'(WINDOW));
  assign pend_sum  = {1'b0, slot_q} + (AW + 1)'(diff);
  assign pend_slot = (pend_sum >= WIN_SUM) ? AW'(pend_sum - WIN_SUM) : AW'(pend_sum);
  assign slot_n1   = inc_slot(slot_q);
  assign slot_n2   = inc_slot(slot_n1);
  assign sweep_end = (sweep_q == SLOT_LAST);
  assign walk_take = ram_rdata_i && (walked_q != WALK_MAX);
  assign walk_last = &acked_p1[SEQ_BITS-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      cat_pkg::S_INIT: begin
        if (sweep_end) begin
          state_d = cat_pkg::S_IDLE;
        end
      end
      cat_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = cat_pkg::S_EVAL;
        end
      end
      cat_pkg::S_EVAL: begin
        if (op_q == cat_pkg::OP_CLEAR) begin
          state_d = cat_pkg::S_CLEAR;
        end else if (is_next && !(&seq_q)) begin
          state_d = cat_pkg::S_WALK;
        end else begin
          state_d = cat_pkg::S_DONE;
        end
      end
      cat_pkg::S_WALK: begin
        if (!walk_take || walk_last) begin
          state_d = cat_pkg::S_DONE;
        end
      end
      cat_pkg::S_CLEAR: begin
        if (sweep_end) begin
          state_d = cat_pkg::S_DONE;
        end
      end
      cat_pkg::S_DONE: begin
        if (out_free_i) begin
          state_d = cat_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cat_pkg::S_INIT;
      end
    endcase
  end

  always_comb begin
    op_d        = op_q;
    seq_d       = seq_q;
    acked_d     = acked_q;
    slot_d      = slot_q;
    walked_d    = walked_q;
    sweep_d     = sweep_q;
    status_d    = status_q;
    in_ready_o  = 1'b0;
    res_load_o  = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = slot_n1;
    ram_wdata_o = 1'b0;
    ram_raddr_o = slot_n2;
    case (state_q)
      cat_pkg::S_INIT, cat_pkg::S_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = sweep_q;
        sweep_d     = sweep_end ? '0 : AW'(sweep_q + 1'b1);
      end
      cat_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d  = op_i;
          seq_d = SEQ_BITS'(seq_i);
        end
      end
      cat_pkg::S_EVAL: begin
        if (op_q == cat_pkg::OP_CLEAR) begin
          acked_d  = '0;
          slot_d   = '0;
          sweep_d  = '0;
          status_d = cat_pkg::ST_CLEARED;
        end else if (is_next) begin
          acked_d  = seq_q;
          slot_d   = slot_n1;
          walked_d = '0;
          ram_we_o = 1'b1;
          status_d = cat_pkg::ST_ADVANCED;
        end else if (is_ahead && in_window) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = pend_slot;
          ram_wdata_o = 1'b1;
          status_d    = cat_pkg::ST_PENDING;
        end else if (is_ahead) begin
          status_d = cat_pkg::ST_DROPPED;
        end else begin
          status_d = cat_pkg::ST_OLD;
        end
      end
      cat_pkg::S_WALK: begin
        // The read data is the pending bit of the chunk after the count.
        if (walk_take) begin
          ram_we_o = 1'b1;
          acked_d  = acked_p1[SEQ_BITS-1:0];
          slot_d   = slot_n1;
          walked_d = WCW'(walked_q + 1'b1);
        end
      end
      cat_pkg::S_DONE: begin
        res_load_o = out_free_i;
      end
      default: begin
        ram_we_o = 1'b0;
      end
    endcase
  end

  assign res_o.acked_count = cat_pkg::SEQ_W'(acked_q);
  assign res_o.complete    = (cat_pkg::SEQ_W'(acked_q) == last_chunk_seq_i);
  assign res_o.status      = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cat_pkg::S_INIT;
      acked_q  <= '0;
      slot_q   <= '0;
      walked_q <= '0;
      sweep_q  <= '0;
      status_q <= cat_pkg::ST_OLD;
    end else begin
      state_q  <= state_d;
      acked_q  <= acked_d;
      slot_q   <= slot_d;
      walked_q <= walked_d;
      sweep_q  <= sweep_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    seq_q <= seq_d;
  end

endmodule

// ===== src/cat_outbuf.sv =====
// Output register holding one finished result until the receiver takes it.
`timescale 1ns / 1ps

module cat_outbuf (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  cat_pkg::res_t                 res_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cat_pkg::SEQ_W-1:0]     acked_count_o,
  output logic                          complete_o,
  output logic [cat_pkg::STATUS_W-1:0]  status_o
);

  logic          valid_q, valid_d;
  cat_pkg::res_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign acked_count_o = res_q.acked_count;
  assign complete_o    = res_q.complete;
  assign status_o      = res_q.status;

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the cumulative acknowledgement tracker: queued chunk stimulus and a result checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int WINDOW       = cat_pkg::DEFAULT_WINDOW;
  localparam int SEQ_BITS     = cat_pkg::DEFAULT_SEQ_BITS;
  localparam int AW           = $clog2(WINDOW);
  localparam int SEQ_MAX      = (1 << SEQ_BITS) - 1;
  localparam int DRAIN_CYCLES = WINDOW + 8;
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int RAND_ITEMS   = 340;

  typedef struct {
    logic                      op;
    logic [cat_pkg::SEQ_W-1:0] seq;
  } chunk_req_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic                         op_i = cat_pkg::OP_ARRIVAL;
  logic [cat_pkg::SEQ_W-1:0]    seq_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [cat_pkg::SEQ_W-1:0]    acked_count_o;
  logic                         complete_o;
  logic [cat_pkg::STATUS_W-1:0] status_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [cat_pkg::SEQ_W-1:0]    last_chunk_seq_i = '0;

  cumulative_ack_tracker #(
    .WINDOW  (WINDOW),
    .SEQ_BITS(SEQ_BITS)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .seq_i           (seq_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .acked_count_o   (acked_count_o),
    .complete_o      (complete_o),
    .status_o        (status_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .last_chunk_seq_i(last_chunk_seq_i)
  );

  always #10 clk_i = ~clk_i;

  // Tracker state mirrored by the testbench.
  int unsigned               acked_cnt = 0;
  bit [WINDOW-1:0]           held_map = '0;
  logic [cat_pkg::SEQ_W-1:0] final_chunk = cat_pkg::LAST_CHUNK_RESET;

  chunk_req_t    chunk_q[$];
  cat_pkg::res_t ack_reports_q[$];
  int            n_issued = 0;
  int            n_checked = 0;
  int            n_errors = 0;
  int            cycle_cnt = 0;
  bit            idle_on = 1'b1;
  int            in_gap = 0;
  int            out_gap = 0;

  function automatic logic [AW-1:0] slot_of(input int unsigned s);
    return AW'(s % WINDOW);
  endfunction

  function automatic cat_pkg::res_t track_chunk(input logic op,
                                                input logic [cat_pkg::SEQ_W-1:0] seq);
    cat_pkg::res_t    r;
    cat_pkg::status_e st;
    int unsigned      s;
    int unsigned      walked;
    s = 32'(seq);
    if (op == cat_pkg::OP_CLEAR) begin
      acked_cnt = 0;
      held_map  = '0;
      st        = cat_pkg::ST_CLEARED;
    end else if (s == acked_cnt + 1) begin
      acked_cnt = s;
      held_map[slot_of(s)] = 1'b0;
      walked = 0;
      while (walked < WINDOW && acked_cnt < SEQ_MAX && held_map[slot_of(acked_cnt + 1)]) begin
        held_map[slot_of(acked_cnt + 1)] = 1'b0;
        acked_cnt++;
        walked++;
      end
      st = cat_pkg::ST_ADVANCED;
    end else if (s > acked_cnt + 1) begin
      if (s - acked_cnt <= WINDOW) begin
        held_map[slot_of(s)] = 1'b1;
        st = cat_pkg::ST_PENDING;
      end else begin
        st = cat_pkg::ST_DROPPED;
      end
    end else begin
      st = cat_pkg::ST_OLD;
    end
    r.acked_count = acked_cnt[cat_pkg::SEQ_W-1:0];
    r.complete    = (acked_cnt[cat_pkg::SEQ_W-1:0] == final_chunk);
    r.status      = st;
    return r;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic queue_chunk(input logic op, input int seq);
    chunk_req_t c;
    c.op  = op;
    c.seq = seq[cat_pkg::SEQ_W-1:0];
    chunk_q.insert(chunk_q.size(), c);
    n_issued++;
  endtask

  // Waits until every queued request has its result checked, then lets the block settle.
  task automatic drain();
    while (n_checked != n_issued) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_final_chunk(input int value);
    drain();
    @(posedge clk_i);
    cfg_valid_i      <= 1'b1;
    last_chunk_seq_i <= value[cat_pkg::SEQ_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    final_chunk = value[cat_pkg::SEQ_W-1:0];
    cfg_valid_i <= 1'b0;
  endtask

  // Request driver.
  always @(posedge clk_i) begin
    chunk_req_t c;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        ack_reports_q.insert(ack_reports_q.size(), track_chunk(op_i, seq_i));
        in_gap = idle_on ? gap_len() : 0;
      end
      if (in_valid_i && !in_ready_o) begin
        // Hold the request until it is taken.
      end else if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap--;
      end else if (chunk_q.size() > 0) begin
        c = chunk_q.pop_front();
        op_i       <= c.op;
        seq_i      <= c.seq;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stalls.
  always @(posedge clk_i) begin
    cat_pkg::res_t e;
    if (out_valid_o && out_ready_i) begin
      if (ack_reports_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result count %0d complete %0b status %0d", $time,
                 acked_count_o, complete_o, status_o);
      end else begin
        e = ack_reports_q.pop_front();
        n_checked++;
        if (acked_count_o !== e.acked_count || complete_o !== e.complete ||
            status_o !== e.status) begin
          n_errors++;
          $display("%0t: mismatch expected count %0d complete %0b status %0d, got %0d %0b %0d",
                   $time, e.acked_count, e.complete, e.status, acked_count_o, complete_o,
                   status_o);
        end
      end
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (out_gap > 0) begin
      out_ready_i <= 1'b0;
      out_gap--;
    end else begin
      out_ready_i <= 1'b1;
      if (idle_on && $urandom_range(0, 99) < 15) out_gap = gap_len();
    end
  end

  initial begin : watchdog
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("cumulative_ack_tracker verification failed");
    $finish;
  end

  initial begin : stimulus
    int n_rand;
    int n;
    int span;
    int j;
    int tmp;
    int r;
    int order[$];

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset value of the final chunk number.
    queue_chunk(cat_pkg::OP_ARRIVAL, 1);
    queue_chunk(cat_pkg::OP_CLEAR, 0);

    write_final_chunk(6);
    queue_chunk(cat_pkg::OP_ARRIVAL, 0);
    queue_chunk(cat_pkg::OP_ARRIVAL, 3);
    queue_chunk(cat_pkg::OP_ARRIVAL, 2);
    queue_chunk(cat_pkg::OP_ARRIVAL, WINDOW);
    queue_chunk(cat_pkg::OP_ARRIVAL, WINDOW + 1);
    queue_chunk(cat_pkg::OP_ARRIVAL, SEQ_MAX);
    queue_chunk(cat_pkg::OP_ARRIVAL, 1);
    queue_chunk(cat_pkg::OP_ARRIVAL, 3);
    queue_chunk(cat_pkg::OP_ARRIVAL, 5);
    queue_chunk(cat_pkg::OP_ARRIVAL, 4);
    queue_chunk(cat_pkg::OP_ARRIVAL, 6);
    queue_chunk(cat_pkg::OP_ARRIVAL, 7);
    queue_chunk(cat_pkg::OP_ARRIVAL, 7 + WINDOW);
    queue_chunk(cat_pkg::OP_ARRIVAL, 8 + WINDOW);
    queue_chunk(cat_pkg::OP_CLEAR, SEQ_MAX);
    queue_chunk(cat_pkg::OP_ARRIVAL, WINDOW);
    queue_chunk(cat_pkg::OP_ARRIVAL, 1);
    queue_chunk(cat_pkg::OP_CLEAR, 0);

    // A final chunk number of zero makes an empty transfer complete.
    write_final_chunk(0);
    queue_chunk(cat_pkg::OP_CLEAR, 12345);
    queue_chunk(cat_pkg::OP_ARRIVAL, 0);
    queue_chunk(cat_pkg::OP_ARRIVAL, 1);
    queue_chunk(cat_pkg::OP_CLEAR, 0);

    // A full window held in reverse order, then the chunk that releases all of it.
    write_final_chunk(WINDOW);
    idle_on = 1'b0;
    for (int s = WINDOW; s >= 2; s--) queue_chunk(cat_pkg::OP_ARRIVAL, s);
    queue_chunk(cat_pkg::OP_ARRIVAL, 1);
    queue_chunk(cat_pkg::OP_ARRIVAL, WINDOW);
    queue_chunk(cat_pkg::OP_ARRIVAL, 0);
    queue_chunk(cat_pkg::OP_ARRIVAL, WINDOW + 2);
    queue_chunk(cat_pkg::OP_ARRIVAL, WINDOW + 1);
    queue_chunk(cat_pkg::OP_CLEAR, 0);

    // Random transfers: shuffled deliveries with noise, then a resend pass.
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      n = $urandom_range(1, 90);
      write_final_chunk(($urandom_range(0, 3) == 0) ? $urandom_range(0, SEQ_MAX) : n);
      idle_on = ($urandom_range(0, 3) != 0);
      queue_chunk(cat_pkg::OP_CLEAR, $urandom_range(0, SEQ_MAX));
      n_rand++;
      for (int pass = 0; pass < 2; pass++) begin
        order.delete();
        for (int i = 1; i <= n; i++) order.insert(order.size(), i);
        r = $urandom_range(0, 2);
        span = (pass == 1) ? 4 : (r == 0) ? 8 : (r == 1) ? 40 : 90;
        for (int i = 0; i < n - 1; i++) begin
          tmp = (span < n - 1 - i) ? span : n - 1 - i;
          j = i + $urandom_range(0, tmp);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        for (int i = 0; i < n; i++) begin
          r = $urandom_range(0, 99);
          if (r < 6) begin
            queue_chunk(cat_pkg::OP_ARRIVAL, $urandom_range(0, SEQ_MAX));
          end else if (r < 10) begin
            queue_chunk(cat_pkg::OP_ARRIVAL, order[$urandom_range(0, i)]);
          end else if (r < 12) begin
            queue_chunk(cat_pkg::OP_ARRIVAL, ($urandom_range(0, 1) == 0) ? 0 : SEQ_MAX);
          end else if (r < 13) begin
            queue_chunk(cat_pkg::OP_CLEAR, $urandom_range(0, SEQ_MAX));
          end
          if (r < 13) n_rand++;
          queue_chunk(cat_pkg::OP_ARRIVAL, order[i]);
          n_rand++;
        end
      end
    end

    drain();
    if (n_errors == 0 && ack_reports_q.size() == 0) begin
      $display("cumulative_ack_tracker verification clean");
    end else begin
      $display("cumulative_ack_tracker verification failed");
    end
    $finish;
  end

endmodule
